### hw/rtl/laser_line_peak_detector_assert.svh
// assertion macros for the laser line peak detector
// expects signals named clk and arst_n in the including module
`ifndef LASER_LINE_PEAK_DETECTOR_ASSERT_SVH
`define LASER_LINE_PEAK_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS

// condition must hold at every edge outside reset
`define LLPD_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LLPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define LLPD_ASSERT(lbl, cond, msg)
`define LLPD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### hw/rtl/lpd_pkg.sv
// shared types and constants for the laser line peak detector
// no dependencies
package lpd_pkg;

	// frame geometry and field widths
	localparam int MAX_COLUMNS = 4096;
	localparam int MAX_ROWS    = 4096;
	localparam int CHAN_W      = 8;
	localparam int LEVEL_W     = 10;
	localparam int COL_W       = 12;
	localparam int ROW_W       = 12;

	// one accepted pixel pair with its row/frame markers
	typedef struct packed {
		logic [CHAN_W-1:0] laser_red;
		logic [CHAN_W-1:0] laser_green;
		logic [CHAN_W-1:0] laser_blue;
		logic [CHAN_W-1:0] tex_red;
		logic [CHAN_W-1:0] tex_green;
		logic [CHAN_W-1:0] tex_blue;
		logic              row_end;
		logic              frame_end;
	} pix_t;

	// one per-row result
	typedef struct packed {
		logic               found;
		logic [COL_W-1:0]   column;
		logic [LEVEL_W-1:0] brightness;
		logic [CHAN_W-1:0]  red;
		logic [CHAN_W-1:0]  green;
		logic [CHAN_W-1:0]  blue;
		logic [ROW_W-1:0]   row;
	} res_t;

endpackage

### hw/rtl/lpd_row_track.sv
// running brightest-pixel tracker for one row plus column/row counters
// depends on lpd_pkg
module lpd_row_track import lpd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  pix_t pix,
	output res_t res
);

	logic [LEVEL_W-1:0] best_level_q;
	logic [COL_W-1:0]   best_column_q;
	logic [CHAN_W-1:0]  best_red_q;
	logic [CHAN_W-1:0]  best_green_q;
	logic [CHAN_W-1:0]  best_blue_q;
	logic [COL_W-1:0]   column_q;
	logic [ROW_W-1:0]   row_q;

	logic [LEVEL_W-1:0] level;
	logic               better;
	logic               last;
	logic [LEVEL_W-1:0] nb_level;
	logic [COL_W-1:0]   nb_column;
	logic [CHAN_W-1:0]  nb_red;
	logic [CHAN_W-1:0]  nb_green;
	logic [CHAN_W-1:0]  nb_blue;
	logic               found;

	// brightness of the laser pixel and strict compare against the best so far
	assign level  = LEVEL_W'(pix.laser_red) + LEVEL_W'(pix.laser_green)
		+ LEVEL_W'(pix.laser_blue);
	assign better = level > best_level_q;
	assign last   = pix.row_end | pix.frame_end;

	// best after this pixel
	assign nb_level  = better ? level : best_level_q;
	assign nb_column = better ? column_q : best_column_q;
	assign nb_red    = better ? pix.tex_red : best_red_q;
	assign nb_green  = better ? pix.tex_green : best_green_q;
	assign nb_blue   = better ? pix.tex_blue : best_blue_q;

	// row result, zeroed fields for an all-black row
	assign found          = nb_level != '0;
	assign res.found      = found;
	assign res.column     = found ? nb_column : '0;
	assign res.brightness = nb_level;
	assign res.red        = found ? nb_red : '0;
	assign res.green      = found ? nb_green : '0;
	assign res.blue       = found ? nb_blue : '0;
	assign res.row        = row_q;

	// state update per pixel, cleared at row end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_level_q  <= '0;
			best_column_q <= '0;
			best_red_q    <= '0;
			best_green_q  <= '0;
			best_blue_q   <= '0;
			column_q      <= '0;
			row_q         <= '0;
		end else if (step) begin
			if (last) begin
				best_level_q  <= '0;
				best_column_q <= '0;
				best_red_q    <= '0;
				best_green_q  <= '0;
				best_blue_q   <= '0;
				column_q      <= '0;
				if (pix.frame_end || row_q == ROW_W'(MAX_ROWS - 1)) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				best_level_q  <= nb_level;
				best_column_q <= nb_column;
				best_red_q    <= nb_red;
				best_green_q  <= nb_green;
				best_blue_q   <= nb_blue;
				if (column_q == COL_W'(MAX_COLUMNS - 1)) begin
					column_q <= '0;
				end else begin
					column_q <= column_q + 1'b1;
				end
			end
		end
	end

endmodule

### hw/rtl/laser_line_peak_detector.sv
// Laser line peak detector, top level.
// One input channel carries pixel pairs (laser RGB and colour RGB at the
// same position) row by row, with row_end marking the last pixel of a row
// and frame_end the last pixel of a frame (it also ends the row). One
// output channel carries a result per row: found flag, column and
// brightness of the first brightest laser pixel, the colour pixel there,
// and the row index within the frame.
// Both channels use valid/stall; a transaction happens on a rising edge
// with valid high and stall low.
// Throughput: one pixel per clock while in_stall is low. The row-end
// pixel's transaction edge fills the input register; the edge that moves
// it on loads the row result into the output register, raising out_valid.
// When the receiver stalls, a waiting result holds and the input register
// still takes pixels; in_stall rises only when a row-end pixel sits in the
// input register while the output register is full and stalled.
// Reset clears the best-pixel state, column and row counts and all valid
// flags; no result is pending afterwards.
// Depends on lpd_pkg, lpd_row_track and laser_line_peak_detector_assert.svh.
`include "laser_line_peak_detector_assert.svh"

module laser_line_peak_detector import lpd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [CHAN_W-1:0]  laser_red,
	input  logic [CHAN_W-1:0]  laser_green,
	input  logic [CHAN_W-1:0]  laser_blue,
	input  logic [CHAN_W-1:0]  tex_red,
	input  logic [CHAN_W-1:0]  tex_green,
	input  logic [CHAN_W-1:0]  tex_blue,
	input  logic               row_end,
	input  logic               frame_end,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               peak_found,
	output logic [COL_W-1:0]   peak_column,
	output logic [LEVEL_W-1:0] peak_brightness,
	output logic [CHAN_W-1:0]  peak_red,
	output logic [CHAN_W-1:0]  peak_green,
	output logic [CHAN_W-1:0]  peak_blue,
	output logic [ROW_W-1:0]   row_index
);

	logic s1_valid_q;
	pix_t s1_q;
	logic out_valid_q;
	res_t out_q;
	res_t res;
	logic s1_last;
	logic s1_done;
	logic in_accept;

	// input stage advances unless its row result has nowhere to go
	assign s1_last   = s1_q.row_end | s1_q.frame_end;
	assign s1_done   = s1_valid_q && !(s1_last && out_valid_q && out_stall);
	assign in_stall  = s1_valid_q && !s1_done;
	assign in_accept = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_done) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			s1_q.laser_red   <= laser_red;
			s1_q.laser_green <= laser_green;
			s1_q.laser_blue  <= laser_blue;
			s1_q.tex_red     <= tex_red;
			s1_q.tex_green   <= tex_green;
			s1_q.tex_blue    <= tex_blue;
			s1_q.row_end     <= row_end;
			s1_q.frame_end   <= frame_end;
		end
	end

	// compare and capture
	lpd_row_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (s1_done),
		.pix    (s1_q),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_done && s1_last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_done && s1_last) begin
			out_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign peak_found      = out_q.found;
	assign peak_column     = out_q.column;
	assign peak_brightness = out_q.brightness;
	assign peak_red        = out_q.red;
	assign peak_green      = out_q.green;
	assign peak_blue       = out_q.blue;
	assign row_index       = out_q.row;

	// checks
	`LLPD_ASSERT(a_stall_only_on_row_end, !in_stall || (s1_valid_q && s1_last && out_valid_q), "input stalled without a blocked row result")
	`LLPD_ASSERT(a_found_matches_level, !out_valid_q || (peak_found == (peak_brightness != '0)), "found flag disagrees with brightness")
	`LLPD_ASSERT(a_black_row_zero, !out_valid_q || peak_found || (peak_column == '0 && peak_red == '0 && peak_green == '0 && peak_blue == '0), "black row result not zeroed")
	`LLPD_ASSERT_NEXT(a_row_end_result, s1_done && s1_last, out_valid_q, "row end gave no result")

endmodule
